// ----- src/mnkm_pkg.sv -----
// Shared types, constants and helper functions for the NRPN knob mapper.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mnkm_pkg;

    localparam int KNOB_COUNT   = 18;
    localparam int BUTTON_COUNT = 9;
    localparam int CTRL_COUNT   = KNOB_COUNT + BUTTON_COUNT;
    localparam int PAIR_SPLIT   = 9;

    localparam int IDX_W  = 5;
    localparam int KA_W   = $clog2(KNOB_COUNT);
    localparam int BA_W   = $clog2(BUTTON_COUNT);
    localparam int VAL_W  = 7;
    localparam int CH_W   = 4;
    localparam int BYTE_W = 8;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LISTEN_CHANNEL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_STEP    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_STEP      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KNOB_MAX       = 8'd3;

    localparam logic [CH_W-1:0]  RST_LISTEN_CHANNEL = 4'd15;
    localparam logic [VAL_W-1:0] RST_COARSE_STEP    = 7'd5;
    localparam logic [VAL_W-1:0] RST_FINE_STEP      = 7'd1;
    localparam logic [VAL_W-1:0] RST_KNOB_MAX       = 7'd127;

    // Controller numbers.
    localparam logic [BYTE_W-1:0] CC_NRPN_MSB = 8'h62;
    localparam logic [BYTE_W-1:0] CC_NRPN_LSB = 8'h63;
    localparam logic [BYTE_W-1:0] CC_DATA_MSB = 8'h06;
    localparam logic [BYTE_W-1:0] CC_DATA_LSB = 8'h26;

    // NRPN LSB codes that select a control bank.
    localparam logic [BYTE_W-1:0] BANK_KNOB_LO = 8'h03;
    localparam logic [BYTE_W-1:0] BANK_KNOB_HI = 8'h0B;
    localparam logic [BYTE_W-1:0] BANK_BUTTON  = 8'h13;
    localparam logic [BYTE_W-1:0] BANK_SPECIAL = 8'h23;

    // NRPN MSB value that maps to control index zero, per linear bank.
    localparam int BASE_KNOB_LO = 'h74;
    localparam int BASE_KNOB_HI = 'h5C - 9;
    localparam int BASE_BUTTON  = 'h44 - 18;
    // The special bank maps MSB 0x14 + k to index 9 * k + 8.
    localparam int SPECIAL_MSB  = 'h14;

    localparam logic [BYTE_W-1:0] BASE_KNOB_LO_B = BYTE_W'(BASE_KNOB_LO);
    localparam logic [BYTE_W-1:0] BASE_KNOB_HI_B = BYTE_W'(BASE_KNOB_HI);
    localparam logic [BYTE_W-1:0] BASE_BUTTON_B  = BYTE_W'(BASE_BUTTON);
    localparam logic [BYTE_W-1:0] SPECIAL_MSB_B  = BYTE_W'(SPECIAL_MSB);
    localparam logic [BYTE_W-1:0] LAST_OFFSET_B  = BYTE_W'(CTRL_COUNT - 1);

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_map;

    typedef struct packed {
        logic              en;
        logic [KA_W-1:0]   addr;
        logic [VAL_W-1:0]  data;
    } t_knob_wr;

    typedef struct packed {
        logic             is_knob;
        logic [IDX_W-1:0] idx;
        logic [BA_W-1:0]  btn;
        logic             up;
    } t_s1;

    // Linear bank: index = msb - base, valid while it stays below CTRL_COUNT.
    function automatic t_map mnkm_lin_map(input logic [BYTE_W-1:0] msb,
                                          input logic [BYTE_W-1:0] base);
        t_map               m;
        logic [BYTE_W-1:0]  off;
        off   = msb - base;
        m.hit = (msb >= base) && (off <= LAST_OFFSET_B);
        m.idx = off[IDX_W-1:0];
        return m;
    endfunction

    function automatic t_map mnkm_map(input logic [BYTE_W-1:0] msb,
                                      input logic [BYTE_W-1:0] lsb);
        t_map              m;
        logic [BYTE_W-1:0] off;
        m   = '0;
        off = msb - SPECIAL_MSB_B;
        case (lsb)
            BANK_KNOB_LO: m = mnkm_lin_map(msb, BASE_KNOB_LO_B);
            BANK_KNOB_HI: m = mnkm_lin_map(msb, BASE_KNOB_HI_B);
            BANK_BUTTON:  m = mnkm_lin_map(msb, BASE_BUTTON_B);
            BANK_SPECIAL: begin
                m.hit = (msb >= SPECIAL_MSB_B) && (off <= 8'd2);
                m.idx = IDX_W'({off[1:0], 3'b000} + {3'b000, off[1:0]} + 5'd8);
            end
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- src/mnkm_ifs.sv -----
// Channel interfaces of the NRPN knob mapper: input messages, result events
// and configuration writes. Depends on mnkm_pkg.
`default_nettype none

interface mnkm_msg_if import mnkm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] status_byte;
    logic [BYTE_W-1:0] data_one;
    logic [BYTE_W-1:0] data_two;

    modport source (output valid, output status_byte, output data_one,
                    output data_two, input ready);
    modport sink   (input valid, input status_byte, input data_one,
                    input data_two, output ready);
endinterface

interface mnkm_evt_if import mnkm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             event_kind;
    logic [IDX_W-1:0] control_index;
    logic [VAL_W-1:0] knob_value;
    logic             engaged;

    modport source (output valid, output event_kind, output control_index,
                    output knob_value, output engaged, input ready);
    modport sink   (input valid, input event_kind, input control_index,
                    input knob_value, input engaged, output ready);
endinterface

interface mnkm_cfg_if import mnkm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/mnkm_knob_ram.sv -----
// Knob value store: a synchronous memory with registered read data and one
// valid flop per entry so unwritten entries read as zero. Depends on mnkm_pkg.
`default_nettype none

module mnkm_knob_ram import mnkm_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic [KA_W-1:0]  i_rd_addr,
    output      logic [VAL_W-1:0] o_rd_data,
    input  wire t_knob_wr         i_wr
);

    logic [VAL_W-1:0]      r_mem [KNOB_COUNT];
    logic [KNOB_COUNT-1:0] r_vld;
    logic [VAL_W-1:0]      r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

// ----- src/midi_nrpn_knob_mapper_core.sv -----
// NRPN knob mapper, top level. Uses mnkm_pkg, the channel interfaces in
// mnkm_ifs.sv and the knob value store mnkm_knob_ram.
`default_nettype none

// The mapper accepts one three-byte MIDI message per clock cycle. Messages on
// a channel other than listen_channel are dropped; controller numbers 0x62,
// 0x63 and 0x06 latch the NRPN MSB, NRPN LSB and data MSB, and 0x26 (data LSB)
// completes a message. A completed message whose NRPN pair maps to a control
// produces exactly one result transaction: either a button change (event_kind
// 1) or a new knob value (event_kind 0). The result is registered: an accepted
// message passes through stage one and then the result register, and a stalled
// result channel holds it there. Knob values live in an 18-entry synchronous
// memory that is read when the message is accepted and written back when the
// message moves into the result register, which a stalled result channel can
// delay. A message whose read lands on the same edge as a write to its knob
// gets the fresh value forwarded, so back-to-back updates of one knob need no
// stall. The sustained rate is one message per cycle, limited only by the
// result channel: while a result waits to be taken and a second one is ready
// behind it, input is held off. Every store comes up zero after reset with no
// clearing pass. Configuration writes are always ready and should be issued
// while no message is in flight.
module midi_nrpn_knob_mapper_core import mnkm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mnkm_msg_if.sink   i_msg,
    mnkm_evt_if.source o_evt,
    mnkm_cfg_if.sink   i_cfg
);

    // Configuration registers.
    logic [CH_W-1:0]  r_listen;
    logic [VAL_W-1:0] r_coarse;
    logic [VAL_W-1:0] r_fine;
    logic [VAL_W-1:0] r_kmax;

    // Latched NRPN fields.
    logic [BYTE_W-1:0] r_nrpn_high;
    logic [BYTE_W-1:0] r_nrpn_low;
    logic [BYTE_W-1:0] r_data_high;

    logic [BUTTON_COUNT-1:0] r_btn;

    // Stage one holds a completed message while its knob value is read.
    logic             r_s1_valid;
    t_s1              r_s1;
    t_s1              n_s1;
    logic             r_fwd_hit;
    logic [VAL_W-1:0] r_fwd_val;

    // Result register.
    logic             r_out_valid;
    logic             r_out_kind;
    logic [IDX_W-1:0] r_out_idx;
    logic [VAL_W-1:0] r_out_val;
    logic             r_out_eng;

    logic             msg_acc;
    logic             ch_hit;
    t_map             map;
    logic             go;
    logic             s1_go;
    logic [VAL_W-1:0] rd_data;
    logic [VAL_W-1:0] cur_val;
    logic [VAL_W-1:0] n_val;
    logic [VAL_W-1:0] step;
    logic [VAL_W:0]   sum;
    logic             flag;
    t_knob_wr         wr;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen <= RST_LISTEN_CHANNEL;
            r_coarse <= RST_COARSE_STEP;
            r_fine   <= RST_FINE_STEP;
            r_kmax   <= RST_KNOB_MAX;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_LISTEN_CHANNEL: r_listen <= i_cfg.data[CH_W-1:0];
                REG_COARSE_STEP:    r_coarse <= i_cfg.data[VAL_W-1:0];
                REG_FINE_STEP:      r_fine   <= i_cfg.data[VAL_W-1:0];
                REG_KNOB_MAX:       r_kmax   <= i_cfg.data[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage one moves on when the result register is free or being emptied;
    // the input is ready whenever stage one is empty or moving on.
    assign s1_go       = r_s1_valid && (!r_out_valid || o_evt.ready);
    assign i_msg.ready = !r_s1_valid || s1_go;
    assign msg_acc     = i_msg.valid && i_msg.ready;
    assign ch_hit      = (i_msg.status_byte[CH_W-1:0] == r_listen);

    // The mapping uses the NRPN pair latched by earlier messages; the data
    // LSB message itself changes neither byte of the pair.
    assign map = mnkm_map(r_nrpn_high, r_nrpn_low);
    assign go  = msg_acc && ch_hit && (i_msg.data_one == CC_DATA_LSB) && map.hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nrpn_high <= '0;
            r_nrpn_low  <= '0;
            r_data_high <= '0;
        end else if (msg_acc && ch_hit) begin
            case (i_msg.data_one)
                CC_NRPN_MSB: r_nrpn_high <= i_msg.data_two;
                CC_NRPN_LSB: r_nrpn_low  <= i_msg.data_two;
                CC_DATA_MSB: r_data_high <= i_msg.data_two;
                default: ;
            endcase
        end
    end

    // Decode the control into knob or button and the paired button.
    always_comb begin
        n_s1.idx     = map.idx;
        n_s1.is_knob = (map.idx < IDX_W'(KNOB_COUNT));
        n_s1.up      = (r_data_high == '0);
        if (!n_s1.is_knob) begin
            n_s1.btn = BA_W'(map.idx - IDX_W'(KNOB_COUNT));
        end else if (map.idx >= IDX_W'(PAIR_SPLIT)) begin
            n_s1.btn = BA_W'(map.idx - IDX_W'(PAIR_SPLIT));
        end else begin
            n_s1.btn = BA_W'(map.idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (go) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    // The stage-one write lands on the same edge that the new read samples,
    // so a hit on that knob takes the value being written instead.
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_s1      <= n_s1;
            r_fwd_hit <= s1_go && r_s1.is_knob && (r_s1.idx == map.idx);
            r_fwd_val <= n_val;
        end
    end

    mnkm_knob_ram u_knob_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (go),
        .i_rd_addr (map.idx[KA_W-1:0]),
        .o_rd_data (rd_data),
        .i_wr      (wr)
    );

    // Knob update: step up with clamp to knob_max, or down with clamp to zero.
    always_comb begin
        cur_val = r_fwd_hit ? r_fwd_val : rd_data;
        flag    = r_btn[r_s1.btn];
        step    = flag ? r_fine : r_coarse;
        sum     = {1'b0, cur_val} + {1'b0, step};
        if (r_s1.up) begin
            n_val = (sum > {1'b0, r_kmax}) ? r_kmax : sum[VAL_W-1:0];
        end else begin
            n_val = (cur_val >= step) ? (cur_val - step) : '0;
        end
        wr.en   = s1_go && r_s1.is_knob;
        wr.addr = r_s1.idx[KA_W-1:0];
        wr.data = n_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btn <= '0;
        end else if (s1_go && !r_s1.is_knob) begin
            r_btn[r_s1.btn] <= r_s1.up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (o_evt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_kind <= !r_s1.is_knob;
            r_out_idx  <= r_s1.idx;
            r_out_val  <= r_s1.is_knob ? n_val : '0;
            r_out_eng  <= r_s1.is_knob ? flag : r_s1.up;
        end
    end

    assign o_evt.valid         = r_out_valid;
    assign o_evt.event_kind    = r_out_kind;
    assign o_evt.control_index = r_out_idx;
    assign o_evt.knob_value    = r_out_val;
    assign o_evt.engaged       = r_out_eng;

endmodule

`default_nettype wire

// ----- test/tb_midi_nrpn_knob_mapper_core.sv -----
// Self-checking testbench for midi_nrpn_knob_mapper_core: drives MIDI messages,
// predicts each knob and button event and compares it with the result channel.
// Depends on mnkm_pkg and the channel interfaces in mnkm_ifs.sv.
`default_nettype none

module tb_midi_nrpn_knob_mapper_core import mnkm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // NRPN MSB values that land on the first control of each bank. The special
    // bank lands on every ninth control, starting at index eight.
    localparam int MSB_AT_KNOB0   = 'h74;
    localparam int MSB_AT_KNOB9   = 'h5C;
    localparam int MSB_AT_BUTTON0 = 'h44;
    localparam int MSB_AT_SPECIAL = 'h14;
    localparam int SPECIAL_STRIDE = 9;
    localparam int SPECIAL_FIRST  = 8;

    localparam logic EVT_KNOB   = 1'b0;
    localparam logic EVT_BUTTON = 1'b1;

    // Not a register of the block; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd4;

    // Cycles to let pass once no event is awaited, so that a message that
    // produces nothing has left the two-stage pipeline.
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PRINTED   = 40;

    typedef struct packed {
        logic [BYTE_W-1:0] status;
        logic [BYTE_W-1:0] ctrl;
        logic [BYTE_W-1:0] value;
    } msg_t;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] level;
        logic             engaged;
    } evt_t;

    logic i_clk;
    logic i_rst_n;

    mnkm_msg_if msg_ch ();
    mnkm_evt_if evt_ch ();
    mnkm_cfg_if cfg_ch ();

    midi_nrpn_knob_mapper_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_ch),
        .o_evt   (evt_ch),
        .i_cfg   (cfg_ch)
    );

    // Mirror of the block's configuration registers.
    logic [CH_W-1:0]  listen_ch;
    logic [VAL_W-1:0] coarse_step;
    logic [VAL_W-1:0] fine_step;
    logic [VAL_W-1:0] knob_ceiling;

    // Mirror of the block's latches and stores.
    logic [BYTE_W-1:0] nrpn_msb;
    logic [BYTE_W-1:0] nrpn_lsb;
    logic [BYTE_W-1:0] data_msb;
    logic [VAL_W-1:0]  knob_level [KNOB_COUNT];
    logic              button_on  [BUTTON_COUNT];

    msg_t pending_msgs[$];
    evt_t awaited_events[$];

    int queued_total;
    int accepted_total;
    int event_count;
    int error_count;
    bit msg_taken;

    // Idling control: gaps_on enables random bursts on both sides, and each
    // side also runs calm stretches of its own with no bursts at all.
    bit gaps_on;
    int msg_hold;
    int msg_calm;
    int evt_hold;
    int evt_calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or loses an event.
    initial begin
        #2_000_000;
        $display("[midi_nrpn_knob_mapper_core] ERROR");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        if (error_count < MAX_PRINTED)
            $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Applies one accepted message to the mirrored state. Returns 1 and fills
    // ev when the message completes an NRPN transfer that maps to a control.
    function automatic bit apply_message(input msg_t m, output evt_t ev);
        int  idx;
        int  pair;
        int  step;
        int  lvl;
        bit  rising;
        ev = '0;
        if (m.status[CH_W-1:0] != listen_ch)
            return 1'b0;
        case (m.ctrl)
            CC_NRPN_MSB: begin
                nrpn_msb = m.value;
                return 1'b0;
            end
            CC_NRPN_LSB: begin
                nrpn_lsb = m.value;
                return 1'b0;
            end
            CC_DATA_MSB: begin
                data_msb = m.value;
                return 1'b0;
            end
            CC_DATA_LSB: ;
            default: return 1'b0;
        endcase

        // The data LSB completes the transfer; the latched NRPN pair picks
        // the control.
        case (nrpn_lsb)
            BANK_KNOB_LO: idx = int'(nrpn_msb) - MSB_AT_KNOB0;
            BANK_KNOB_HI: idx = 9 + int'(nrpn_msb) - MSB_AT_KNOB9;
            BANK_BUTTON:  idx = KNOB_COUNT + int'(nrpn_msb) - MSB_AT_BUTTON0;
            BANK_SPECIAL: idx = (int'(nrpn_msb) - MSB_AT_SPECIAL) * SPECIAL_STRIDE
                                + SPECIAL_FIRST;
            default: return 1'b0;
        endcase
        if (idx < 0 || idx >= KNOB_COUNT + BUTTON_COUNT)
            return 1'b0;

        rising   = (data_msb == '0);
        ev.index = idx[IDX_W-1:0];
        if (idx >= KNOB_COUNT) begin
            button_on[idx - KNOB_COUNT] = rising;
            ev.kind    = EVT_BUTTON;
            ev.level   = '0;
            ev.engaged = rising;
        end else begin
            // Knobs 0-8 pair with buttons 0-8, and knobs 9-17 with the same.
            pair = (idx >= BUTTON_COUNT) ? idx - BUTTON_COUNT : idx;
            step = button_on[pair] ? int'(fine_step) : int'(coarse_step);
            lvl  = int'(knob_level[idx]);
            if (rising) begin
                // Clamping to the ceiling may pull a high value down.
                lvl = lvl + step;
                if (lvl > int'(knob_ceiling))
                    lvl = int'(knob_ceiling);
            end else begin
                lvl = lvl - step;
                if (lvl < 0)
                    lvl = 0;
            end
            knob_level[idx] = lvl[VAL_W-1:0];
            ev.kind    = EVT_KNOB;
            ev.level   = lvl[VAL_W-1:0];
            ev.engaged = button_on[pair];
        end
        return 1'b1;
    endfunction

    // Message source. A new message is presented when the line is free or the
    // current one was taken at the last rising edge.
    always @(negedge i_clk) begin : feed_messages
        msg_t nxt;
        if (msg_calm > 0)
            msg_calm--;
        else if ($urandom_range(0, 60) == 0)
            msg_calm = $urandom_range(10, 40);
        if (!msg_ch.valid || msg_taken) begin
            if (msg_hold > 0) begin
                msg_hold--;
                msg_ch.valid <= 1'b0;
            end else if (pending_msgs.size() == 0) begin
                msg_ch.valid <= 1'b0;
            end else if (gaps_on && msg_calm == 0 && $urandom_range(0, 6) == 0) begin
                msg_hold = $urandom_range(0, 3);
                msg_ch.valid <= 1'b0;
            end else begin
                nxt = pending_msgs.pop_front();
                msg_ch.valid       <= 1'b1;
                msg_ch.status_byte <= nxt.status;
                msg_ch.data_one    <= nxt.ctrl;
                msg_ch.data_two    <= nxt.value;
            end
        end
    end

    // Event sink with random back-pressure.
    always @(negedge i_clk) begin : take_events
        if (evt_calm > 0)
            evt_calm--;
        else if ($urandom_range(0, 60) == 0)
            evt_calm = $urandom_range(10, 40);
        if (evt_hold > 0) begin
            evt_hold--;
            evt_ch.ready <= 1'b0;
        end else if (gaps_on && evt_calm == 0 && $urandom_range(0, 5) == 0) begin
            evt_hold = $urandom_range(0, 3);
            evt_ch.ready <= 1'b0;
        end else begin
            evt_ch.ready <= 1'b1;
        end
    end

    // Monitor: checks each event transaction against the oldest prediction,
    // then predicts from the message transaction of the same edge. An event
    // never belongs to a message accepted at the same edge, so this order is
    // safe.
    always @(posedge i_clk) begin : watch
        evt_t got;
        evt_t want;
        msg_t m;
        msg_taken = 1'b0;
        if (i_rst_n) begin
            if (evt_ch.valid && evt_ch.ready) begin
                got = '{evt_ch.event_kind, evt_ch.control_index,
                        evt_ch.knob_value, evt_ch.engaged};
                if (awaited_events.size() == 0) begin
                    flag_mismatch($sformatf("unexpected event kind %0d index %0d",
                                            got.kind, got.index));
                end else begin
                    want = awaited_events.pop_front();
                    if (got.kind !== want.kind)
                        flag_mismatch($sformatf("event %0d: event_kind %0d, want %0d",
                                                event_count, got.kind, want.kind));
                    if (got.index !== want.index)
                        flag_mismatch($sformatf("event %0d: control_index %0d, want %0d",
                                                event_count, got.index, want.index));
                    if (got.level !== want.level)
                        flag_mismatch($sformatf("event %0d: knob_value %0d, want %0d",
                                                event_count, got.level, want.level));
                    if (got.engaged !== want.engaged)
                        flag_mismatch($sformatf("event %0d: engaged %0d, want %0d",
                                                event_count, got.engaged, want.engaged));
                end
                event_count++;
            end
            if (msg_ch.valid && msg_ch.ready) begin
                msg_taken = 1'b1;
                accepted_total++;
                m = '{msg_ch.status_byte, msg_ch.data_one, msg_ch.data_two};
                if (apply_message(m, want))
                    awaited_events.push_back(want);
            end
        end
    end

    task automatic queue_msg(input logic [BYTE_W-1:0] status,
                             input logic [BYTE_W-1:0] ctrl,
                             input logic [BYTE_W-1:0] value);
        pending_msgs.push_back('{status, ctrl, value});
        queued_total++;
    endtask

    // Status byte on the listened channel; the high nibble is not decoded.
    function automatic logic [BYTE_W-1:0] on_channel();
        return {4'($urandom), listen_ch};
    endfunction

    function automatic logic [BYTE_W-1:0] off_channel();
        return {4'($urandom), listen_ch ^ 4'($urandom_range(1, 15))};
    endfunction

    // Queues the NRPN pair of control idx, picking one of the banks that can
    // reach it.
    task automatic queue_select(input int idx);
        logic [BYTE_W-1:0] msb;
        logic [BYTE_W-1:0] lsb;
        lsb = BANK_KNOB_LO;
        msb = 8'(MSB_AT_KNOB0 + idx);
        case ($urandom_range(0, 3))
            0: begin
                lsb = BANK_KNOB_HI;
                msb = 8'(MSB_AT_KNOB9 + idx - 9);
            end
            1: begin
                lsb = BANK_BUTTON;
                msb = 8'(MSB_AT_BUTTON0 + idx - KNOB_COUNT);
            end
            2: if (idx % SPECIAL_STRIDE == SPECIAL_FIRST) begin
                lsb = BANK_SPECIAL;
                msb = 8'(MSB_AT_SPECIAL + idx / SPECIAL_STRIDE);
            end
            default: ;
        endcase
        if ($urandom_range(0, 1)) begin
            queue_msg(on_channel(), CC_NRPN_MSB, msb);
            queue_msg(on_channel(), CC_NRPN_LSB, lsb);
        end else begin
            queue_msg(on_channel(), CC_NRPN_LSB, lsb);
            queue_msg(on_channel(), CC_NRPN_MSB, msb);
        end
    endtask

    // Mostly well-formed NRPN transfers with random content: a select, then a
    // run of data writes to the same control so that knobs reach both clamps.
    // The rest is stray controllers on the channel and traffic on other
    // channels, which does not count toward the target.
    task automatic queue_random_traffic(input int target);
        int                made;
        int                reps;
        int                pick;
        logic [BYTE_W-1:0] v;
        made = 0;
        while (made < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                if ($urandom_range(0, 4) != 0) begin
                    queue_select($urandom_range(0, CTRL_COUNT - 1));
                end else begin
                    case ($urandom_range(0, 4))
                        0: v = BANK_KNOB_LO;
                        1: v = BANK_KNOB_HI;
                        2: v = BANK_BUTTON;
                        3: v = BANK_SPECIAL;
                        default: v = 8'($urandom);
                    endcase
                    queue_msg(on_channel(), CC_NRPN_MSB, 8'($urandom));
                    queue_msg(on_channel(), CC_NRPN_LSB, v);
                end
                made += 2;
                reps = $urandom_range(1, 6);
                repeat (reps) begin
                    if ($urandom_range(0, 2) == 0) begin
                        v = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
                        queue_msg(on_channel(), CC_DATA_MSB, v);
                        made++;
                    end
                    if ($urandom_range(0, 7) == 0)
                        queue_msg(off_channel(), 8'($urandom), 8'($urandom));
                    queue_msg(on_channel(), CC_DATA_LSB, 8'($urandom));
                    made++;
                end
            end else if (pick < 9) begin
                queue_msg(on_channel(), 8'($urandom), 8'($urandom));
                made++;
            end else begin
                queue_msg(off_channel(), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    // Waits until every queued message has been taken and every predicted
    // event has arrived, then lets the pipeline run empty.
    task automatic wait_for_idle();
        while (accepted_total != queued_total || awaited_events.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        // The block only keeps the low bits of each register.
        case (idx)
            REG_LISTEN_CHANNEL: listen_ch    = val[CH_W-1:0];
            REG_COARSE_STEP:    coarse_step  = val[VAL_W-1:0];
            REG_FINE_STEP:      fine_step    = val[VAL_W-1:0];
            REG_KNOB_MAX:       knob_ceiling = val[VAL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Directed opening under the reset configuration (channel 15, coarse 5,
    // fine 1, ceiling 127).
    task automatic queue_directed();
        logic [BYTE_W-1:0] s;
        s = 8'hBF;
        // Wrong channel, unknown controller, and a transfer completed while
        // the NRPN pair still holds its reset value.
        queue_msg(8'h00, CC_DATA_LSB, 8'hFF);
        queue_msg(8'hFF, 8'hFF, 8'h00);
        queue_msg(8'h0F, CC_DATA_LSB, 8'h00);
        // Knob 0 up by the coarse step, down, then held at zero.
        queue_msg(s, CC_NRPN_MSB, 8'h74);
        queue_msg(s, CC_NRPN_LSB, BANK_KNOB_LO);
        queue_msg(s, CC_DATA_LSB, 8'h00);
        queue_msg(s, CC_DATA_MSB, 8'hFF);
        queue_msg(s, CC_DATA_LSB, 8'h7F);
        queue_msg(s, CC_DATA_LSB, 8'h01);
        // Engage button 0, then knob 9 goes up by the fine step.
        queue_msg(s, CC_NRPN_MSB, 8'h44);
        queue_msg(s, CC_NRPN_LSB, BANK_BUTTON);
        queue_msg(s, CC_DATA_MSB, 8'h00);
        queue_msg(s, CC_DATA_LSB, 8'h00);
        queue_msg(s, CC_NRPN_MSB, 8'h5C);
        queue_msg(s, CC_NRPN_LSB, BANK_KNOB_HI);
        queue_msg(s, CC_DATA_LSB, 8'h40);
        // Special bank: button 8 engaged, then released.
        queue_msg(s, CC_NRPN_MSB, 8'h16);
        queue_msg(s, CC_NRPN_LSB, BANK_SPECIAL);
        queue_msg(s, CC_DATA_LSB, 8'hFF);
        queue_msg(s, CC_DATA_MSB, 8'h80);
        queue_msg(s, CC_DATA_LSB, 8'h00);
        // Special bank just above and below its range, an unknown bank,
        // and the low knob bank one past the last control and at it.
        queue_msg(s, CC_NRPN_MSB, 8'h17);
        queue_msg(s, CC_DATA_LSB, 8'h00);
        queue_msg(s, CC_NRPN_MSB, 8'h13);
        queue_msg(s, CC_DATA_LSB, 8'h00);
        queue_msg(s, CC_NRPN_LSB, 8'hFF);
        queue_msg(s, CC_DATA_LSB, 8'h00);
        queue_msg(s, CC_NRPN_MSB, 8'h8F);
        queue_msg(s, CC_NRPN_LSB, BANK_KNOB_LO);
        queue_msg(s, CC_DATA_LSB, 8'h00);
        queue_msg(s, CC_NRPN_MSB, 8'h8E);
        queue_msg(s, CC_DATA_LSB, 8'h00);
    endtask

    // Steps are mostly small so knobs travel a while before they clamp.
    function automatic logic [CFG_DATA_W-1:0] random_step();
        logic [VAL_W-1:0] v;
        v = $urandom_range(0, 1) ? 7'($urandom_range(0, 12)) : 7'($urandom);
        return {1'($urandom), v};
    endfunction

    initial begin : main
        int ph;
        i_rst_n            = 1'b0;
        msg_ch.valid       = 1'b0;
        msg_ch.status_byte = '0;
        msg_ch.data_one    = '0;
        msg_ch.data_two    = '0;
        evt_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        gaps_on            = 1'b1;
        listen_ch          = 4'd15;
        coarse_step        = 7'd5;
        fine_step          = 7'd1;
        knob_ceiling       = 7'd127;
        nrpn_msb           = '0;
        nrpn_lsb           = '0;
        data_msb           = '0;
        foreach (knob_level[i])
            knob_level[i] = '0;
        foreach (button_on[i])
            button_on[i] = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_directed();
        wait_for_idle();

        // Extremes: channel 0, largest coarse step, zero fine step and a zero
        // ceiling, written with bit 7 set where it must be dropped.
        write_register(REG_LISTEN_CHANNEL, 8'hF0);
        write_register(REG_COARSE_STEP, 8'h7F);
        write_register(REG_FINE_STEP, 8'h80);
        write_register(REG_KNOB_MAX, 8'h80);
        queue_random_traffic(100);
        wait_for_idle();

        // Opposite extremes: zero coarse step, largest fine step, full range.
        write_register(REG_LISTEN_CHANNEL, 8'($urandom_range(0, 15)));
        write_register(REG_COARSE_STEP, 8'h00);
        write_register(REG_FINE_STEP, 8'hFF);
        write_register(REG_KNOB_MAX, 8'h7F);
        write_register(REG_SPARE, 8'($urandom));
        queue_random_traffic(100);
        wait_for_idle();

        // Random settings; the ceiling may drop below stored knob values. The
        // last phase runs without any idling on either side.
        for (ph = 0; ph < 5; ph++) begin
            write_register(REG_LISTEN_CHANNEL, 8'($urandom));
            write_register(REG_COARSE_STEP, random_step());
            write_register(REG_FINE_STEP, random_step());
            write_register(REG_KNOB_MAX, 8'($urandom));
            gaps_on = (ph != 4);
            queue_random_traffic(100);
            wait_for_idle();
        end

        if (error_count == 0)
            $display("[midi_nrpn_knob_mapper_core] OK");
        else
            $display("[midi_nrpn_knob_mapper_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
